@@ rtl/core/fprc_pkg.sv @@
// ----------------------------------------------------------------------------
// fprc_pkg
// Shared types and constants for the framed packet receiver.
// ----------------------------------------------------------------------------
package fprc_pkg;

  localparam logic [1:0] FUNC_RX   = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_PEEK = 2'd2;

  localparam logic [7:0] SYNC_BYTE = 8'h06;
  localparam logic [7:0] KIND_BYTE = 8'h85;
  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam int unsigned HDR_LEN  = 5;
  localparam int unsigned DEST_POS = 3;
  localparam int unsigned LEN_POS  = 4;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH,       // write rx byte at tail
    CMD_RD_OFS,     // ring read at head + offset
    CMD_LATCH_LEN,  // capture size byte from last read
    CMD_CHK_SYNC,   // no datapath action
    CMD_CRC_CLR,
    CMD_CRC_BYTE,   // fold last read byte into CRC
    CMD_SHIFT_FRM,  // shift last read byte into frame register
    CMD_STORE,      // write frame to store
    CMD_DROP1,
    CMD_DROPPKT,
    CMD_ACCESS      // read/peek store
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [8:0] ofs;
  } ctrl_t;

  typedef struct packed {
    logic [8:0] count;
    logic [7:0] rd_byte;
    logic [8:0] len;
    logic       crc_ok;
    logic       ring_full;
  } stat_t;

  function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] d);
    logic [7:0] a;
    a = acc;
    for (int b = 0; b < 8; b++) begin
      if (a[0] ^ d[b]) a = (a >> 1) ^ CRC_POLY;
      else a = a >> 1;
    end
    return a;
  endfunction

endpackage

@@ rtl/core/fprc_if.sv @@
// ----------------------------------------------------------------------------
// fprc_in_if / fprc_out_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface fprc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;
  logic [7:0] entry_index;
  modport source (output valid, func, rx_byte, entry_index, input ready);
  modport sink (input valid, func, rx_byte, entry_index, output ready);
endinterface

interface fprc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] entry_value;
  logic               entry_fresh;
  modport source (output valid, entry_value, entry_fresh, input ready);
  modport sink (input valid, entry_value, entry_fresh, output ready);
endinterface

@@ rtl/core/fprc_datapath.sv @@
// ----------------------------------------------------------------------------
// fprc_datapath
// Receive ring, CRC accumulator, frame assembly, value store and fresh flags.
// ----------------------------------------------------------------------------
module fprc_datapath #(
  parameter int unsigned STORE_ENTRIES    = 256,
  parameter int unsigned MAX_PACKET_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fprc_pkg::ctrl_t      ctrl_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           entry_index_i,
  input  logic                 clear_flag_i,
  output fprc_pkg::stat_t      stat_o,
  output logic signed [15:0]   entry_value_o,
  output logic                 entry_fresh_o
);
  localparam int unsigned RW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned SW = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;

  logic [7:0]    ring_mem [MAX_PACKET_BYTES];
  logic [RW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    rd_q;
  logic [8:0]    len_q;
  logic [7:0]    crc_q;
  logic [23:0]   frm_q;
  logic [15:0]   store_mem [STORE_ENTRIES];
  logic [STORE_ENTRIES-1:0] fresh_q;
  logic signed [15:0] val_q;
  logic          fresh_o_q;

  // modular index of head + offset
  function automatic logic [RW-1:0] wrap(logic [RW-1:0] h, logic [9:0] o);
    logic [10:0] s;
    s = {{(11-RW){1'b0}}, h} + {1'b0, o};
    if (s >= 11'(MAX_PACKET_BYTES)) s = s - 11'(MAX_PACKET_BYTES);
    if (s >= 11'(MAX_PACKET_BYTES)) s = s - 11'(MAX_PACKET_BYTES);
    if (s >= 11'(MAX_PACKET_BYTES)) s = s - 11'(MAX_PACKET_BYTES);
    if (s >= 11'(MAX_PACKET_BYTES)) s = s - 11'(MAX_PACKET_BYTES);
    if (s >= 11'(MAX_PACKET_BYTES)) s = s - 11'(MAX_PACKET_BYTES);
    return s[RW-1:0];
  endfunction

  logic [RW-1:0] rd_addr, wr_addr;
  logic [9:0]    pkt_total;
  logic [31:0]   frm_w;
  logic [16:0]   frm_idx;
  logic          idx_in;

  // full frame: three shifted bytes plus the byte just read
  assign frm_w     = {frm_q, rd_q};
  assign rd_addr   = wrap(head_q, {1'b0, ctrl_i.ofs});
  assign wr_addr   = wrap(head_q, 10'(count_q));
  assign pkt_total = {1'b0, len_q} + 10'(fprc_pkg::HDR_LEN + 1);
  assign frm_idx   = {1'b0, frm_w[31:16]};
  assign idx_in    = frm_idx < 17'(STORE_ENTRIES);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    unique case (ctrl_i.cmd)
      fprc_pkg::CMD_PUSH:
        if (count_q < CW'(MAX_PACKET_BYTES)) count_d = count_q + CW'(1);
      fprc_pkg::CMD_DROP1: begin
        head_d  = wrap(head_q, 10'd1);
        count_d = count_q - CW'(1);
      end
      fprc_pkg::CMD_DROPPKT: begin
        head_d  = wrap(head_q, pkt_total);
        count_d = count_q - CW'(pkt_total);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      fresh_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (ctrl_i.cmd == fprc_pkg::CMD_STORE && idx_in)
        fresh_q[frm_w[16+SW-1:16]] <= 1'b1;
      else if (ctrl_i.cmd == fprc_pkg::CMD_ACCESS && clear_flag_i &&
               {9'd0, entry_index_i} < 17'(STORE_ENTRIES))
        fresh_q[SW'(entry_index_i)] <= 1'b0;
    end
  end

  // value store is cleared by per-entry valid (fresh-independent) bits
  logic [STORE_ENTRIES-1:0] written_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) written_q <= '0;
    else if (ctrl_i.cmd == fprc_pkg::CMD_STORE && idx_in)
      written_q[frm_w[16+SW-1:16]] <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == fprc_pkg::CMD_PUSH && count_q < CW'(MAX_PACKET_BYTES))
      ring_mem[wr_addr] <= rx_byte_i;
    rd_q <= ring_mem[rd_addr];
    if (ctrl_i.cmd == fprc_pkg::CMD_LATCH_LEN) len_q <= {1'b0, rd_q};
    if (ctrl_i.cmd == fprc_pkg::CMD_CRC_CLR) crc_q <= 8'h00;
    else if (ctrl_i.cmd == fprc_pkg::CMD_CRC_BYTE)
      crc_q <= fprc_pkg::crc8_step(crc_q, rd_q);
    if (ctrl_i.cmd == fprc_pkg::CMD_SHIFT_FRM) frm_q <= {frm_q[15:0], rd_q};
    if (ctrl_i.cmd == fprc_pkg::CMD_STORE && idx_in)
      store_mem[frm_w[16+SW-1:16]] <= frm_w[15:0];
    if (ctrl_i.cmd == fprc_pkg::CMD_ACCESS) begin
      if ({9'd0, entry_index_i} < 17'(STORE_ENTRIES)) begin
        val_q     <= written_q[SW'(entry_index_i)] ?
                     $signed(store_mem[SW'(entry_index_i)]) : 16'sd0;
        fresh_o_q <= fresh_q[SW'(entry_index_i)];
      end else begin
        val_q     <= 16'sd0;
        fresh_o_q <= 1'b0;
      end
    end
  end

  assign stat_o.count     = 9'(count_q);
  assign stat_o.rd_byte   = rd_q;
  assign stat_o.len       = len_q;
  assign stat_o.crc_ok    = (crc_q == rd_q);
  assign stat_o.ring_full = (count_q >= CW'(MAX_PACKET_BYTES));
  assign entry_value_o    = val_q;
  assign entry_fresh_o    = fresh_o_q;
endmodule

@@ rtl/core/fprc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fprc_ctrl
// Sequencer: accepts beats, rescans the ring, walks CRC and frame stores.
// ----------------------------------------------------------------------------
module fprc_ctrl #(
  parameter int unsigned MAX_PACKET_BYTES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      func_i,
  output logic            clear_flag_o,
  input  logic [7:0]      own_address_i,
  input  fprc_pkg::stat_t stat_i,
  output fprc_pkg::ctrl_t ctrl_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_SCAN, S_SYNC, S_HDR, S_LEN, S_CRC, S_CHK, S_FRM, S_DONE
  } state_e;

  state_e     state_q;
  logic [8:0] ofs_q;
  logic [1:0] phase_q;   // header byte checks / frame byte count
  logic       hdr_bad_q;
  logic       out_v_q;

  logic       accept;
  assign in_ready_o   = (state_q == S_IDLE) && !out_v_q;
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_v_q;
  // store access happens on the accepting edge
  assign clear_flag_o = (func_i == fprc_pkg::FUNC_READ);

  logic [9:0] total;
  assign total = {1'b0, stat_i.len} + 10'(fprc_pkg::HDR_LEN + 1);

  always_comb begin
    ctrl_o.cmd = fprc_pkg::CMD_NONE;
    ctrl_o.ofs = ofs_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && func_i == fprc_pkg::FUNC_RX) ctrl_o.cmd = fprc_pkg::CMD_PUSH;
        else if (accept && (func_i == fprc_pkg::FUNC_READ ||
                            func_i == fprc_pkg::FUNC_PEEK))
          ctrl_o.cmd = fprc_pkg::CMD_ACCESS;
      end
      S_SCAN: ctrl_o.ofs = '0;  // head byte
      S_SYNC: if (stat_i.rd_byte != fprc_pkg::SYNC_BYTE) ctrl_o.cmd = fprc_pkg::CMD_DROP1;
      S_HDR:  if (phase_q == 2'd3) ctrl_o.cmd = fprc_pkg::CMD_LATCH_LEN;
      S_LEN:  ctrl_o.cmd = fprc_pkg::CMD_CRC_CLR;
      S_CRC:  if (ofs_q > 9'(fprc_pkg::HDR_LEN)) ctrl_o.cmd = fprc_pkg::CMD_CRC_BYTE;
      S_CHK:  ctrl_o.cmd = (hdr_bad_q || !stat_i.crc_ok) ? fprc_pkg::CMD_DROP1
                                                          : fprc_pkg::CMD_NONE;
      S_FRM: begin
        if (phase_q == 2'd3 && ofs_q > 9'(fprc_pkg::HDR_LEN)) ctrl_o.cmd = fprc_pkg::CMD_STORE;
        else if (ofs_q > 9'(fprc_pkg::HDR_LEN)) ctrl_o.cmd = fprc_pkg::CMD_SHIFT_FRM;
      end
      S_DONE: ctrl_o.cmd = fprc_pkg::CMD_DROPPKT;
      default: ;
    endcase
  end

  // ring read at ofs_q lands in rd_byte on the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ofs_q     <= '0;
      phase_q   <= '0;
      hdr_bad_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept) begin
          ofs_q <= '0;
          priority if (func_i == fprc_pkg::FUNC_RX) state_q <= S_SCAN;
          else if (func_i == fprc_pkg::FUNC_READ || func_i == fprc_pkg::FUNC_PEEK)
            state_q <= S_ACC;
          else state_q <= S_IDLE;
        end
        S_ACC: begin
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          ofs_q <= 9'd1;
          if (stat_i.count == 9'd0) state_q <= S_IDLE;
          else state_q <= S_SYNC;
        end
        S_SYNC: begin
          if (stat_i.rd_byte != fprc_pkg::SYNC_BYTE) state_q <= S_SCAN;
          else if (stat_i.count < 9'(fprc_pkg::HDR_LEN)) state_q <= S_IDLE;
          else begin
            ofs_q     <= 9'd2;  // read for kind byte (offset 1) issued now
            phase_q   <= 2'd0;
            hdr_bad_q <= 1'b0;
            state_q   <= S_HDR;
          end
        end
        // rd_byte here: phase 0 -> offset 1, 1 -> 2, 2 -> 3, 3 -> 4
        S_HDR: begin
          ofs_q   <= ofs_q + 9'd1;
          phase_q <= phase_q + 2'd1;
          if (phase_q == 2'd0 && stat_i.rd_byte != fprc_pkg::KIND_BYTE) hdr_bad_q <= 1'b1;
          if (phase_q == 2'd2 && stat_i.rd_byte != own_address_i) hdr_bad_q <= 1'b1;
          if (phase_q == 2'd3) state_q <= S_LEN;
        end
        S_LEN: begin
          ofs_q <= 9'(fprc_pkg::HDR_LEN);
          if (hdr_bad_q || stat_i.len[1:0] != 2'd0 ||
              total > 10'(MAX_PACKET_BYTES)) begin
            state_q <= S_CHK;
            hdr_bad_q <= 1'b1;
          end else if ({1'b0, stat_i.count} < total) state_q <= S_IDLE;
          else state_q <= S_CRC;
        end
        S_CRC: begin
          ofs_q <= ofs_q + 9'd1;
          if (ofs_q == 9'(fprc_pkg::HDR_LEN) + stat_i.len) state_q <= S_CHK;
        end
        S_CHK: begin
          phase_q <= 2'd0;
          ofs_q   <= 9'(fprc_pkg::HDR_LEN);
          if (hdr_bad_q || !stat_i.crc_ok) state_q <= S_SCAN;
          else state_q <= S_FRM;
        end
        S_FRM: begin
          ofs_q <= ofs_q + 9'd1;
          if (ofs_q > 9'(fprc_pkg::HDR_LEN)) phase_q <= phase_q + 2'd1;
          if (ofs_q == 9'(fprc_pkg::HDR_LEN) + stat_i.len) state_q <= S_DONE;
        end
        S_DONE: state_q <= S_SCAN;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/framed_packet_receiver_crc8.sv @@
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc8
// Byte-stream deframer with CRC-8 check and a value store with fresh flags.
// ----------------------------------------------------------------------------
// Each byte beat is buffered in a MAX_PACKET_BYTES ring and the ring is then
// rescanned by a sequencer that reads one ring byte per cycle: it discards
// bytes that are not a good packet start, checks the header, then makes a CRC
// pass and a frame store pass over a complete packet. A read or peek beat
// returns one result beat; a byte beat returns none. The store and flags come
// out of reset cleared, with no clearing pass.
module framed_packet_receiver_crc8 #(
  parameter int unsigned STORE_ENTRIES    = 256,
  parameter int unsigned MAX_PACKET_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  fprc_in_if.sink    in_if,
  fprc_out_if.source out_if
);
  logic [7:0]      own_address_q;
  fprc_pkg::ctrl_t ctrl;
  fprc_pkg::stat_t stat;
  logic            clear_flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) own_address_q <= 8'd0;
    else if (cfg_we_i) own_address_q <= cfg_wdata_i;
  end

  fprc_ctrl #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .func_i(in_if.func),
    .clear_flag_o(clear_flag), .own_address_i(own_address_q),
    .stat_i(stat), .ctrl_o(ctrl),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready)
  );

  fprc_datapath #(
    .STORE_ENTRIES(STORE_ENTRIES), .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .rx_byte_i(in_if.rx_byte), .entry_index_i(in_if.entry_index),
    .clear_flag_i(clear_flag), .stat_o(stat),
    .entry_value_o(out_if.entry_value), .entry_fresh_o(out_if.entry_fresh)
  );
endmodule
